[rtl/shra_pkg.sv]
// Package for the sample history ring: field widths, register and command
// codes, and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package shra_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CNT_W     = 7;
  localparam int unsigned SUM_W     = DATA_W + CNT_W;
  localparam int unsigned DIV_CNT_W = $clog2(SUM_W);

  typedef enum logic [1:0] {
    MODE_ALL = 2'd0,
    MODE_AVG = 2'd1,
    MODE_MIN = 2'd2,
    MODE_MAX = 2'd3
  } mode_e;

  typedef enum logic {
    REG_RING_LENGTH = 1'b0,
    REG_AGG_MODE    = 1'b1
  } reg_index_e;

  typedef enum logic {
    CMD_PUT   = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef struct packed {
    logic put;
    logic q_start;
    logic rd;
    logic div_ld;
    logic div_step;
    logic emit_agg;
    logic emit_empty;
  } ctl_cmd_t;

  typedef struct packed {
    logic held_zero;
    logic k_last;
    logic div_done;
    logic q_all;
    logic q_avg;
  } dp_status_t;

endpackage

`default_nettype wire

[rtl/shra_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module shra_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                            wdata_i,
  input  wire logic                                        re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[rtl/shra_ctrl.sv]
// Controller state machine for the sample history ring.
// Depends on shra_pkg for the command and status structs.
`default_nettype none

module shra_ctrl
  import shra_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  input  wire logic       cmd_i,
  input  wire dp_status_t status_i,
  output logic            busy,
  output ctl_cmd_t        cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_TAIL,
    S_DIVLD,
    S_DIV,
    S_EMIT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          if (cmd_i == CMD_PUT) begin
            cmd_o.put = 1'b1;
          end else if (status_i.held_zero) begin
            cmd_o.emit_empty = 1'b1;
          end else begin
            cmd_o.q_start = 1'b1;
            state_d       = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd_o.rd = 1'b1;
        if (status_i.k_last) begin
          state_d = S_TAIL;
        end
      end
      S_TAIL: begin
        if (status_i.q_all) begin
          state_d = S_IDLE;
        end else if (status_i.q_avg) begin
          state_d = S_DIVLD;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_DIVLD: begin
        cmd_o.div_ld = 1'b1;
        state_d      = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd_o.emit_agg = 1'b1;
        state_d        = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

`default_nettype wire

[rtl/shra_dp.sv]
// Datapath for the sample history ring: configuration, ring pointers,
// sample RAM, aggregate unit, bit-serial divider and result registers.
// Depends on shra_pkg and shra_ram.
`default_nettype none

module shra_dp
  import shra_pkg::*;
#(
  parameter int unsigned MAX_DEPTH = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_index_i,
  input  wire logic [CNT_W-1:0]  cfg_wdata_i,
  input  wire logic [DATA_W-1:0] sample_in_i,
  input  wire ctl_cmd_t          cmd_i,
  output dp_status_t             status_o,
  output logic                   result_valid_o,
  output logic [DATA_W-1:0]      sample_value_o,
  output logic [CNT_W-1:0]       sample_count_o,
  output logic [DATA_W-1:0]      first_sequence_o,
  output logic                   is_empty_o,
  output logic                   last_of_run_o
);

  localparam int unsigned AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  logic [CNT_W-1:0]     len_q;
  mode_e                mode_q;
  logic [AW-1:0]        wpos_q;
  logic                 wrap_q;
  logic [DATA_W-1:0]    seq_q;

  logic [CNT_W-1:0]     held_q;
  logic [DATA_W-1:0]    first_q;
  logic [CNT_W-1:0]     qlen_q;
  mode_e                qmode_q;
  logic [AW-1:0]        ptr_q;
  logic [AW-1:0]        k_q;
  logic                 rvld_q;
  logic                 rlast_q;
  logic                 rfirst_q;
  logic [SUM_W-1:0]     acc_q;
  logic [DATA_W-1:0]    agg_q;
  logic [SUM_W-1:0]     quo_q;
  logic [CNT_W-1:0]     rem_q;
  logic [DIV_CNT_W-1:0] dcnt_q;

  logic [CNT_W-1:0]     eff_len;
  logic [CNT_W-1:0]     held;
  logic [CNT_W-1:0]     wpos_inc;
  logic [CNT_W-1:0]     ptr_inc;
  logic                 do_put;
  logic [DATA_W-1:0]    rdata;
  logic [CNT_W:0]       rem_sh;
  logic [CNT_W:0]       rem_diff;
  logic                 div_ge;
  logic                 take_new;

  assign eff_len  = (len_q > CNT_W'(MAX_DEPTH)) ? CNT_W'(MAX_DEPTH) : len_q;
  assign held     = wrap_q ? eff_len : CNT_W'(wpos_q);
  assign wpos_inc = CNT_W'(wpos_q) + CNT_W'(1);
  assign ptr_inc  = CNT_W'(ptr_q) + CNT_W'(1);
  assign do_put   = cmd_i.put && (eff_len != '0);

  assign rem_sh   = {rem_q, quo_q[SUM_W-1]};
  assign rem_diff = rem_sh - {1'b0, held_q};
  assign div_ge   = (rem_sh >= {1'b0, held_q});

  assign take_new = rfirst_q ||
                    ((qmode_q == MODE_MIN) ? (rdata < agg_q) : (rdata > agg_q));

  assign status_o.held_zero = (held == '0);
  assign status_o.k_last    = (CNT_W'(k_q) == (held_q - CNT_W'(1)));
  assign status_o.div_done  = (dcnt_q == DIV_CNT_W'(SUM_W - 1));
  assign status_o.q_all     = (qmode_q == MODE_ALL);
  assign status_o.q_avg     = (qmode_q == MODE_AVG);

  shra_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (do_put),
    .waddr_i (wpos_q),
    .wdata_i (sample_in_i),
    .re_i    (cmd_i.rd),
    .raddr_i (ptr_q),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q          <= '0;
      mode_q         <= MODE_ALL;
      wpos_q         <= '0;
      wrap_q         <= 1'b0;
      seq_q          <= '0;
      rvld_q         <= 1'b0;
      result_valid_o <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == REG_RING_LENGTH) begin
          len_q  <= cfg_wdata_i;
          wpos_q <= '0;
          wrap_q <= 1'b0;
          seq_q  <= '0;
        end else begin
          mode_q <= mode_e'(cfg_wdata_i[1:0]);
        end
      end else if (do_put) begin
        seq_q <= seq_q + DATA_W'(1);
        if (wpos_inc >= eff_len) begin
          wpos_q <= '0;
          wrap_q <= 1'b1;
        end else begin
          wpos_q <= wpos_inc[AW-1:0];
        end
      end
      rvld_q         <= cmd_i.rd;
      result_valid_o <= cmd_i.emit_empty || cmd_i.emit_agg ||
                        (rvld_q && (qmode_q == MODE_ALL));
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.q_start) begin
      held_q   <= held;
      first_q  <= seq_q - DATA_W'(held);
      qlen_q   <= eff_len;
      qmode_q  <= mode_q;
      ptr_q    <= wrap_q ? wpos_q : '0;
      k_q      <= '0;
      acc_q    <= '0;
      rfirst_q <= 1'b1;
    end
    if (cmd_i.rd) begin
      rlast_q <= status_o.k_last;
      k_q     <= k_q + AW'(1);
      if (ptr_inc >= qlen_q) begin
        ptr_q <= '0;
      end else begin
        ptr_q <= ptr_inc[AW-1:0];
      end
    end
    if (rvld_q) begin
      rfirst_q <= 1'b0;
      acc_q    <= acc_q + SUM_W'(rdata);
      if (take_new) begin
        agg_q <= rdata;
      end
    end
    if (cmd_i.div_ld) begin
      quo_q  <= acc_q;
      rem_q  <= '0;
      dcnt_q <= '0;
    end
    if (cmd_i.div_step) begin
      quo_q  <= {quo_q[SUM_W-2:0], div_ge};
      rem_q  <= div_ge ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      dcnt_q <= dcnt_q + DIV_CNT_W'(1);
    end

    if (cmd_i.emit_empty) begin
      sample_value_o   <= '0;
      sample_count_o   <= '0;
      first_sequence_o <= seq_q;
      is_empty_o       <= 1'b1;
      last_of_run_o    <= 1'b1;
    end else if (cmd_i.emit_agg) begin
      sample_value_o   <= (qmode_q == MODE_AVG) ? quo_q[DATA_W-1:0] : agg_q;
      sample_count_o   <= CNT_W'(1);
      first_sequence_o <= first_q;
      is_empty_o       <= 1'b0;
      last_of_run_o    <= 1'b1;
    end else if (rvld_q && (qmode_q == MODE_ALL)) begin
      sample_value_o   <= rdata;
      sample_count_o   <= held_q;
      first_sequence_o <= first_q;
      is_empty_o       <= 1'b0;
      last_of_run_o    <= rlast_q;
    end
  end

endmodule

`default_nettype wire

[rtl/sample_history_ring_aggregate_top.sv]
// Top level of the sample history ring with min/max/average query.
// A put leaves busy low. A query holds busy while it reads the N held
// samples (one RAM read per cycle); min/max then emits the aggregate and
// average runs the divider first (one quotient bit per cycle, 39-bit sum).
// An empty query answers in the next cycle, busy low. Words pass the RAM
// read and output registers; the receiver cannot stall. Reset is async.
`default_nettype none

module sample_history_ring_aggregate_top
  import shra_pkg::*;
#(
  parameter int unsigned MAX_DEPTH = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_index_i,
  input  wire logic [CNT_W-1:0]  cfg_wdata_i,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              cmd_i,
  input  wire logic [DATA_W-1:0] sample_in_i,
  output logic                   result_valid_o,
  output logic [DATA_W-1:0]      sample_value_o,
  output logic [CNT_W-1:0]       sample_count_o,
  output logic [DATA_W-1:0]      first_sequence_o,
  output logic                   is_empty_o,
  output logic                   last_of_run_o
);

  ctl_cmd_t   ctl_cmd;
  dp_status_t dp_status;

  shra_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .cmd_i    (cmd_i),
    .status_i (dp_status),
    .busy     (busy),
    .cmd_o    (ctl_cmd)
  );

  shra_dp #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .sample_in_i      (sample_in_i),
    .cmd_i            (ctl_cmd),
    .status_o         (dp_status),
    .result_valid_o   (result_valid_o),
    .sample_value_o   (sample_value_o),
    .sample_count_o   (sample_count_o),
    .first_sequence_o (first_sequence_o),
    .is_empty_o       (is_empty_o),
    .last_of_run_o    (last_of_run_o)
  );

endmodule

`default_nettype wire

[rtl/shra_checker.sv]
// Port-level checks on the sample history ring, bound to the top level.
// Depends on shra_pkg for field widths and command codes.
`default_nettype none

module shra_checker
  import shra_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              cmd_i,
  input wire logic              result_valid_o,
  input wire logic [CNT_W-1:0]  sample_count_o,
  input wire logic [DATA_W-1:0] first_sequence_o,
  input wire logic              is_empty_o,
  input wire logic              last_of_run_o
);

  a_empty_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && is_empty_o |-> (sample_count_o == '0) && last_of_run_o)
    else $error("empty reply word is malformed");

  a_put_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (cmd_i == CMD_PUT) |=> !busy)
    else $error("put raised busy");

  a_query_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (cmd_i == CMD_QUERY) |=> busy || (result_valid_o && is_empty_o))
    else $error("query neither started nor answered empty");

  a_run_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_of_run_o |=>
      result_valid_o && $stable(first_sequence_o) && $stable(sample_count_o))
    else $error("sample run broken or header changed");

endmodule

bind sample_history_ring_aggregate_top shra_checker u_shra_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start            (start),
  .busy             (busy),
  .cmd_i            (cmd_i),
  .result_valid_o   (result_valid_o),
  .sample_count_o   (sample_count_o),
  .first_sequence_o (first_sequence_o),
  .is_empty_o       (is_empty_o),
  .last_of_run_o    (last_of_run_o)
);

`default_nettype wire

[verif/tb.sv]
// Self-checking testbench for sample_history_ring_aggregate_top: directed and random puts,
// queries and register writes, checked word by word against a scoreboard predictor.
// Depends on shra_pkg and the top level of the sample history ring.
`timescale 1ns / 1ps

import shra_pkg::*;

typedef struct packed {
  logic [DATA_W-1:0] value;
  logic [CNT_W-1:0]  count;
  logic [DATA_W-1:0] first_seq;
  logic              empty;
  logic              last;
} ring_word_t;

class sample_ring_scoreboard;
  logic [DATA_W-1:0] store [64];
  int unsigned       wr_pos;
  bit                wrapped;
  logic [DATA_W-1:0] seq;
  int unsigned       ring_len;
  mode_e             agg_mode;
  ring_word_t        words [$];
  int unsigned       errors;

  function new();
    foreach (store[i]) store[i] = '0;
    wr_pos   = 0;
    wrapped  = 0;
    seq      = '0;
    ring_len = 0;
    agg_mode = MODE_ALL;
    errors   = 0;
  endfunction

  function int unsigned pending();
    return words.size();
  endfunction

  function void expect_word(ring_word_t w);
    words.insert(words.size(), w);
  endfunction

  function int unsigned active_depth();
    return (ring_len > 64) ? 64 : ring_len;
  endfunction

  function logic [DATA_W-1:0] sample_at_age(int unsigned k);
    int unsigned idx;
    idx = (wrapped ? wr_pos : 0) + k;
    if (idx >= active_depth()) idx -= active_depth();
    return store[idx];
  endfunction

  function void write_reg(reg_index_e idx, logic [CNT_W-1:0] data);
    if (idx == REG_RING_LENGTH) begin
      ring_len = data;
      wr_pos   = 0;
      wrapped  = 0;
      seq      = '0;
    end else begin
      agg_mode = mode_e'(data[1:0]);
    end
  endfunction

  function void note_item(cmd_e cmd, logic [DATA_W-1:0] data);
    int unsigned       depth;
    int unsigned       held;
    logic [DATA_W-1:0] first;
    logic [DATA_W-1:0] acc;
    logic [DATA_W-1:0] v;
    logic [63:0]       sum;
    depth = active_depth();
    if (cmd == CMD_PUT) begin
      if (depth != 0) begin
        store[wr_pos] = data;
        wr_pos++;
        if (wr_pos >= depth) begin
          wr_pos  = 0;
          wrapped = 1;
        end
        seq++;
      end
      return;
    end
    held  = wrapped ? depth : wr_pos;
    first = seq - DATA_W'(held);
    if (held == 0) begin
      expect_word(ring_word_t'{value: '0, count: '0, first_seq: first, empty: 1'b1,
                               last: 1'b1});
      return;
    end
    if (agg_mode == MODE_ALL) begin
      for (int unsigned k = 0; k < held; k++) begin
        expect_word(ring_word_t'{value: sample_at_age(k), count: CNT_W'(held),
                                 first_seq: first, empty: 1'b0, last: (k + 1 == held)});
      end
      return;
    end
    if (agg_mode == MODE_AVG) begin
      sum = '0;
      for (int unsigned k = 0; k < held; k++) sum += 64'(sample_at_age(k));
      acc = DATA_W'(sum / 64'(held));
    end else begin
      acc = sample_at_age(0);
      for (int unsigned k = 1; k < held; k++) begin
        v = sample_at_age(k);
        if ((agg_mode == MODE_MIN) ? (v < acc) : (v > acc)) acc = v;
      end
    end
    expect_word(ring_word_t'{value: acc, count: CNT_W'(1), first_seq: first, empty: 1'b0,
                             last: 1'b1});
  endfunction

  function void compare_field(string name, logic [DATA_W-1:0] exp, logic [DATA_W-1:0] act);
    if (exp !== act) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp, act);
      errors++;
    end
  endfunction

  function void check_word(ring_word_t got);
    ring_word_t exp;
    if (words.size() == 0) begin
      $display("%0t: unexpected word, expected none, actual value %h count %0d",
               $time, got.value, got.count);
      errors++;
      return;
    end
    exp = words.pop_front();
    compare_field("sample_value", exp.value, got.value);
    compare_field("sample_count", DATA_W'(exp.count), DATA_W'(got.count));
    compare_field("first_sequence", exp.first_seq, got.first_seq);
    compare_field("is_empty", DATA_W'(exp.empty), DATA_W'(got.empty));
    compare_field("last_of_run", DATA_W'(exp.last), DATA_W'(got.last));
  endfunction
endclass

module tb;

  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES = 60;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic              cfg_index_i = REG_RING_LENGTH;
  logic [CNT_W-1:0]  cfg_wdata_i = '0;
  logic              start = 1'b0;
  logic              busy;
  logic              cmd_i = CMD_PUT;
  logic [DATA_W-1:0] sample_in_i = '0;
  logic              result_valid_o;
  logic [DATA_W-1:0] sample_value_o;
  logic [CNT_W-1:0]  sample_count_o;
  logic [DATA_W-1:0] first_sequence_o;
  logic              is_empty_o;
  logic              last_of_run_o;

  sample_ring_scoreboard sb = new();

  sample_history_ring_aggregate_top i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .start           (start),
    .busy            (busy),
    .cmd_i           (cmd_i),
    .sample_in_i     (sample_in_i),
    .result_valid_o  (result_valid_o),
    .sample_value_o  (sample_value_o),
    .sample_count_o  (sample_count_o),
    .first_sequence_o(first_sequence_o),
    .is_empty_o      (is_empty_o),
    .last_of_run_o   (last_of_run_o)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o === 1'b1) begin
        sb.check_word('{value: sample_value_o, count: sample_count_o,
                        first_seq: first_sequence_o, empty: is_empty_o,
                        last: last_of_run_o});
      end
      if (cfg_we_i) sb.write_reg(reg_index_e'(cfg_index_i), cfg_wdata_i);
      if (start && busy === 1'b0) sb.note_item(cmd_e'(cmd_i), sample_in_i);
    end
  end

  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((start && busy === 1'b0) || result_valid_o === 1'b1 || cfg_we_i) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("FAIL");
    $finish;
  end

  task automatic send_word(cmd_e cmd, logic [DATA_W-1:0] data, int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start       <= 1'b1;
    cmd_i       <= cmd;
    sample_in_i <= data;
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  task automatic write_reg(reg_index_e idx, logic [CNT_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0 || busy !== 1'b0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [DATA_W-1:0] pick_sample();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r == 2) return DATA_W'($urandom_range(0, 15));
    return $urandom;
  endfunction

  function automatic int unsigned pick_gap(bit quiet);
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin
    int unsigned       items;
    int unsigned       phase;
    int unsigned       n_items;
    int unsigned       cur_len;
    int unsigned       r;
    int unsigned       query_odds;
    bit                quiet;
    logic [CNT_W-1:0]  mode_word;
    logic [DATA_W-1:0] edge_vals [5];

    edge_vals = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero length after reset: the put is dropped and the query sees an empty ring.
    send_word(CMD_PUT, '1, 0);
    send_word(CMD_QUERY, 32'hA5A5_5A5A, 0);
    drain();

    write_reg(REG_RING_LENGTH, 7'd4);
    write_reg(REG_AGG_MODE, CNT_W'(MODE_ALL));
    send_word(CMD_QUERY, '1, 0);
    foreach (edge_vals[i]) send_word(CMD_PUT, edge_vals[i], 0);
    send_word(CMD_QUERY, '0, 0);
    drain();
    write_reg(REG_AGG_MODE, CNT_W'(MODE_AVG));
    send_word(CMD_QUERY, '0, 0);
    drain();
    write_reg(REG_AGG_MODE, CNT_W'(MODE_MIN));
    send_word(CMD_QUERY, '1, 0);
    drain();
    write_reg(REG_AGG_MODE, 7'h7F);
    send_word(CMD_QUERY, '0, 0);
    drain();

    write_reg(REG_RING_LENGTH, 7'd1);
    send_word(CMD_PUT, 32'h1234_5678, 0);
    send_word(CMD_PUT, '1, 0);
    send_word(CMD_QUERY, '0, 0);
    drain();

    items = 0;
    phase = 0;
    cur_len = 1;
    while (items < 270) begin
      mode_word = CNT_W'($urandom_range(0, 3) | ($urandom_range(0, 31) << 2));
      r = $urandom_range(0, 9);
      if (phase > 1 && r < 2) begin
        write_reg(REG_AGG_MODE, mode_word);
      end else begin
        if (phase == 0) begin
          cur_len = 127;
        end else if (phase == 1) begin
          cur_len = 64;
        end else begin
          r = $urandom_range(0, 15);
          case (r)
            0: cur_len = 0;
            1: cur_len = 64;
            2: cur_len = $urandom_range(65, 127);
            3: cur_len = $urandom_range(9, 63);
            default: cur_len = $urandom_range(1, 8);
          endcase
        end
        if ($urandom_range(0, 1) == 1) begin
          write_reg(REG_RING_LENGTH, CNT_W'(cur_len));
          write_reg(REG_AGG_MODE, mode_word);
        end else begin
          write_reg(REG_AGG_MODE, mode_word);
          write_reg(REG_RING_LENGTH, CNT_W'(cur_len));
        end
      end

      if (cur_len >= 33) begin
        n_items = ((cur_len > 64) ? 64 : cur_len) + $urandom_range(5, 15);
        query_odds = 9;
      end else begin
        n_items = $urandom_range(6, 20);
        query_odds = 3;
      end
      quiet = ($urandom_range(0, 3) == 0);
      for (int unsigned i = 0; i < n_items; i++) begin
        send_word(($urandom_range(0, query_odds) == 0) ? CMD_QUERY : CMD_PUT,
                  pick_sample(), pick_gap(quiet));
        items++;
      end
      drain();
      phase++;
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
